// ===== src/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants
// Field widths, result codes and the controller/datapath command and status
// structures of the LFU cache core.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 16;
	localparam int SIZE_W   = 48;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 7;
	localparam int STAMP_W  = 64;

	localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

	localparam logic [STATUS_W-1:0] STS_HIT          = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INSERTED     = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_INSERTED = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic scan_step;
		logic wr_a;
		logic wr_b;
		logic push_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_last;
		logic out_free;
	} sts_t;

endpackage

// ===== src/lfu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_if: request and response channels
// Valid/ready channels carrying one lookup request word and one result word.
// ----------------------------------------------------------------------------
interface lfu_req_if;
	import lfu_pkg::*;

	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    key_tag;
	logic                fill_ok;
	logic [HANDLE_W-1:0] fill_handle;
	logic [SIZE_W-1:0]   fill_size;

	modport source (output valid, key_tag, fill_ok, fill_handle, fill_size, input ready);
	modport sink   (input valid, key_tag, fill_ok, fill_handle, fill_size, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] out_handle;
	logic [SIZE_W-1:0]   out_size;
	logic                evict_valid;
	logic [HANDLE_W-1:0] evict_handle;

	modport source (output valid, status, out_handle, out_size, evict_valid, evict_handle,
		input ready);
	modport sink   (input valid, status, out_handle, out_size, evict_valid, evict_handle,
		output ready);
endinterface

// ===== src/lfu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/lfu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ctrl: sequencing controller
// Steps through the clearing pass, the table scan, the write-back and the
// hand-off of the result word.
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lfu_pkg::sts_t sts,
	output lfu_pkg::cmd_t cmd
);
	import lfu_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_WR_A  = 3'd4;
	localparam logic [2:0] S_WR_B  = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.cnt_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.cnt_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_a  = 1'b1;
				state_nxt = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_b  = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.push_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== src/lfu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_dp: table datapath
// Holds the entry memory, the scan accumulators, the use clock, the capacity
// register and the result register.
// ----------------------------------------------------------------------------
module lfu_dp #(
	parameter int ENTRIES    = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfu_pkg::cmd_t                     cmd,
	output lfu_pkg::sts_t                     sts,
	input  logic [lfu_pkg::KEY_W-1:0]         key_tag,
	input  logic                              fill_ok,
	input  logic [lfu_pkg::HANDLE_W-1:0]      fill_handle,
	input  logic [lfu_pkg::SIZE_W-1:0]        fill_size,
	input  logic                              cfg_we,
	input  logic [lfu_pkg::CFG_W-1:0]         cfg_wdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lfu_pkg::STATUS_W-1:0]      status,
	output logic [lfu_pkg::HANDLE_W-1:0]      out_handle,
	output logic [lfu_pkg::SIZE_W-1:0]        out_size,
	output logic                              evict_valid,
	output logic [lfu_pkg::HANDLE_W-1:0]      evict_handle
);
	import lfu_pkg::*;

	localparam int AW         = $clog2(ENTRIES);
	localparam int UW         = $clog2(ENTRIES + 1);
	localparam int CMPW       = (UW > CFG_W) ? UW : CFG_W;
	localparam int OFF_STAMP  = 0;
	localparam int OFF_COUNT  = OFF_STAMP + STAMP_W;
	localparam int OFF_SIZE   = OFF_COUNT + COUNT_BITS;
	localparam int OFF_HANDLE = OFF_SIZE + SIZE_W;
	localparam int OFF_KEY    = OFF_HANDLE + HANDLE_W;
	localparam int OFF_VALID  = OFF_KEY + KEY_W;
	localparam int WORD_W     = OFF_VALID + 1;

	// Item, configuration and clock state.
	logic [KEY_W-1:0]      key_q;
	logic                  fill_ok_q;
	logic [HANDLE_W-1:0]   fill_handle_q;
	logic [SIZE_W-1:0]     fill_size_q;
	logic [CFG_W-1:0]      cap_q;
	logic [STAMP_W-1:0]    use_clock_q;
	logic [AW-1:0]         idx_q;

	// Read pipeline.
	logic                  rd_vld_s1;
	logic [AW-1:0]         idx_s1;
	logic [WORD_W-1:0]     rd_data;

	// Scan accumulators.
	logic [UW-1:0]         used_q;
	logic                  hit_found_q;
	logic [AW-1:0]         hit_idx_q;
	logic [HANDLE_W-1:0]   hit_handle_q;
	logic [SIZE_W-1:0]     hit_size_q;
	logic [COUNT_BITS-1:0] hit_count_q;
	logic                  free_found_q;
	logic [AW-1:0]         free_idx_q;
	logic                  vic_found_q;
	logic [AW-1:0]         vic_idx_q;
	logic [COUNT_BITS-1:0] vic_count_q;
	logic [STAMP_W-1:0]    vic_stamp_q;
	logic [HANDLE_W-1:0]   vic_handle_q;

	// Result register.
	logic                  out_vld_q;
	logic [STATUS_W-1:0]   status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [SIZE_W-1:0]     out_size_q;
	logic                  evict_valid_q;
	logic [HANDLE_W-1:0]   evict_handle_q;

	logic                  rd_valid;
	logic [KEY_W-1:0]      rd_key;
	logic [HANDLE_W-1:0]   rd_handle;
	logic [SIZE_W-1:0]     rd_size;
	logic [COUNT_BITS-1:0] rd_count;
	logic [STAMP_W-1:0]    rd_stamp;
	logic                  vic_better;

	logic                  used_ge;
	logic                  do_evict;
	logic                  need_inval;
	logic                  do_insert;
	logic [AW-1:0]         slot;
	logic [COUNT_BITS-1:0] cnt_next;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic                  idx_last;

	assign rd_valid  = rd_data[OFF_VALID];
	assign rd_key    = rd_data[OFF_KEY +: KEY_W];
	assign rd_handle = rd_data[OFF_HANDLE +: HANDLE_W];
	assign rd_size   = rd_data[OFF_SIZE +: SIZE_W];
	assign rd_count  = rd_data[OFF_COUNT +: COUNT_BITS];
	assign rd_stamp  = rd_data[OFF_STAMP +: STAMP_W];

	assign vic_better = !vic_found_q || (rd_count < vic_count_q) ||
		((rd_count == vic_count_q) && (rd_stamp < vic_stamp_q));

	assign idx_last     = (idx_q == AW'(ENTRIES - 1));
	assign sts.cnt_last = idx_last;
	assign sts.out_free = !out_vld_q || out_ready;

	// A zero capacity acts as one; one above the table size acts as the table size.
	assign used_ge = ((cap_q == '0) ? (used_q != '0) : (CMPW'(used_q) >= CMPW'(cap_q))) ||
		(used_q == UW'(ENTRIES));

	assign do_evict   = !hit_found_q && fill_ok_q && used_ge && vic_found_q;
	assign need_inval = do_evict && free_found_q && (free_idx_q < vic_idx_q);
	assign slot       = (do_evict && !need_inval) ? vic_idx_q : free_idx_q;
	assign do_insert  = !hit_found_q && fill_ok_q && (do_evict || free_found_q);
	assign cnt_next   = (hit_count_q == {COUNT_BITS{1'b1}}) ? hit_count_q
		: hit_count_q + 1'b1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		if (cmd.clr_step) begin
			ram_we = 1'b1;
		end else if (cmd.wr_a) begin
			ram_we    = need_inval;
			ram_waddr = vic_idx_q;
		end else if (cmd.wr_b) begin
			if (hit_found_q) begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = {1'b1, key_q, hit_handle_q, hit_size_q, cnt_next, use_clock_q};
			end else begin
				ram_we    = do_insert;
				ram_waddr = slot;
				ram_wdata = {1'b1, key_q, fill_handle_q, fill_size_q,
					COUNT_BITS'(1), use_clock_q};
			end
		end
	end

	lfu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.scan_step),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			use_clock_q  <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			used_q       <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.clr_step || cmd.scan_step) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.load_item) begin
				used_q       <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				vic_found_q  <= 1'b0;
			end else if (rd_vld_s1) begin
				if (rd_valid) begin
					used_q <= used_q + 1'b1;
					if (!hit_found_q && (rd_key == key_q)) begin
						hit_found_q <= 1'b1;
					end
					if (vic_better) begin
						vic_found_q <= 1'b1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.wr_b && (hit_found_q || do_insert)) begin
				use_clock_q <= use_clock_q + 1'b1;
			end
			if (cmd.push_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q         <= key_tag;
			fill_ok_q     <= fill_ok;
			fill_handle_q <= fill_handle;
			fill_size_q   <= fill_size;
		end
		idx_s1 <= idx_q;
		if (rd_vld_s1 && rd_valid) begin
			if (!hit_found_q && (rd_key == key_q)) begin
				hit_idx_q    <= idx_s1;
				hit_handle_q <= rd_handle;
				hit_size_q   <= rd_size;
				hit_count_q  <= rd_count;
			end
			if (vic_better) begin
				vic_idx_q    <= idx_s1;
				vic_count_q  <= rd_count;
				vic_stamp_q  <= rd_stamp;
				vic_handle_q <= rd_handle;
			end
		end
		if (rd_vld_s1 && !rd_valid && !free_found_q && !cmd.load_item) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.push_out) begin
			if (hit_found_q) begin
				status_q       <= STS_HIT;
				out_handle_q   <= hit_handle_q;
				out_size_q     <= hit_size_q;
				evict_valid_q  <= 1'b0;
				evict_handle_q <= '0;
			end else if (!fill_ok_q) begin
				status_q       <= STS_NOT_INSERTED;
				out_handle_q   <= '0;
				out_size_q     <= '0;
				evict_valid_q  <= 1'b0;
				evict_handle_q <= '0;
			end else begin
				status_q       <= STS_INSERTED;
				out_handle_q   <= fill_handle_q;
				out_size_q     <= fill_size_q;
				evict_valid_q  <= do_evict;
				evict_handle_q <= do_evict ? vic_handle_q : '0;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign out_handle   = out_handle_q;
	assign out_size     = out_size_q;
	assign evict_valid  = evict_valid_q;
	assign evict_handle = evict_handle_q;

endmodule

// ===== src/lfu_cache_lookup_fill_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_lookup_fill_core: fully associative LFU table with LRU tie-break
// Looks up a key, counts its use on a hit and fills it on a miss, evicting
// the least frequently used, least recently used entry at capacity.
// ----------------------------------------------------------------------------
// Usage: a request word (key_tag, fill_ok, fill_handle, fill_size) enters on
// the req channel; exactly one result word (status, out_handle, out_size,
// evict_valid, evict_handle) leaves on the rsp channel for each request.
// Both channels transfer a word on a clock edge where valid and ready are high.
// Each request scans the whole entry memory through its single read port, one
// entry per cycle, then writes back in the S_WR_A and S_WR_B states. The block
// takes one request at a time: req.ready stays low from acceptance until the
// result word has been loaded into the output register.
// After reset the block sweeps the whole entry memory once to mark all
// entries empty; req.ready stays low during that pass. The capacity register
// may be written with cfg_we at any time the block is idle, including during
// the clearing pass. The result sits in an output register, so the next request
// can be accepted and scanned while the previous word waits; if the receiver
// still stalls when the new result is ready, the block holds it and waits.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_fill_core #(
	parameter int ENTRIES    = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lfu_req_if.sink                   req,
	lfu_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata
);
	import lfu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences clear, scan, write-back and result hand-off.
	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the entry memory and every register holding table state.
	lfu_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.key_tag      (req.key_tag),
		.fill_ok      (req.fill_ok),
		.fill_handle  (req.fill_handle),
		.fill_size    (req.fill_size),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.status       (rsp.status),
		.out_handle   (rsp.out_handle),
		.out_size     (rsp.out_size),
		.evict_valid  (rsp.evict_valid),
		.evict_handle (rsp.evict_handle)
	);

	// An accepted request always starts its scan on the next cycle.
	a_load_then_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> cmd.scan_step)
		else $error("scan did not start after an accepted request");

	// Table writes never overlap a scan read.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !(cmd.wr_a || cmd.wr_b || cmd.clr_step))
		else $error("table write during scan");

	// A result is only loaded when the output register is free.
	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |-> sts.out_free)
		else $error("result loaded over a pending word");

	// A new request is never taken while a scan is running.
	a_ready_not_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !cmd.scan_step && !cmd.clr_step)
		else $error("request ready during scan or clear");

endmodule
